FILE: src/can_id_mask_filter_table_macros.svh
// Assertion macros shared by the acceptance filter table RTL.
`ifndef CAN_ID_MASK_FILTER_TABLE_MACROS_SVH
`define CAN_ID_MASK_FILTER_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define CMFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, during reset as well.
`define CMFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CMFT_ASSERT(lbl, prop, msg)
`define CMFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/cmft_pkg.sv
// Types and constants of the CAN acceptance filter table.
`timescale 1ns / 1ps

package cmft_pkg;

  localparam int unsigned FuncW      = 2;
  localparam int unsigned IdW        = 29;
  localparam int unsigned DataW      = 64;
  localparam int unsigned KindW      = 2;
  localparam int unsigned OutIdxW    = 5;
  localparam int unsigned ElapsedW   = 16;
  localparam int unsigned MaxResults = 32;
  localparam int unsigned ResCntW    = 6;

  localparam logic [ElapsedW-1:0] ElapsedMax   = 16'hFFFF;
  localparam logic [ElapsedW-1:0] TimeoutReset = 16'd2000;

  typedef logic [IdW-1:0]     id_t;
  typedef logic [OutIdxW-1:0] out_idx_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [KindW-1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_MATCH = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

endpackage

FILE: src/can_id_mask_filter_table.sv
// Add and tick give their result in the cycle after the item is accepted.
// A frame walks the filter memory one entry a cycle through its single read port,
// unless a busy output stalls it; its last result leaves at the end of the walk.
// One item at a time: the next item is accepted once the walk is over.
// Reset (rst_ni low, asynchronous) empties the table, saturates the elapsed counter
// (not alive) and sets the timeout to 2000 ms; the filter memory itself is not cleared.
`timescale 1ns / 1ps

module can_id_mask_filter_table #(
  parameter int unsigned FILTER_ENTRIES = 32,
  parameter int unsigned ID_BITS        = 29
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration: timeout in milliseconds.
  input  logic                                 cfg_we_i,
  input  logic [cmft_pkg::ElapsedW-1:0]        cfg_wdata_i,
  // Input items.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cmft_pkg::FuncW-1:0]           func_i,
  input  logic [cmft_pkg::IdW-1:0]             ident_i,
  input  logic [cmft_pkg::IdW-1:0]             mask_i,
  input  logic [cmft_pkg::DataW-1:0]           frame_data_i,
  // Result items.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [cmft_pkg::KindW-1:0]           kind_o,
  output logic [cmft_pkg::OutIdxW-1:0]         match_index_o,
  output logic [cmft_pkg::IdW-1:0]             frame_id_o,
  output logic [cmft_pkg::DataW-1:0]           payload_o,
  output logic                                 alive_o,
  output logic                                 last_o
);

`include "can_id_mask_filter_table_macros.svh"

  // Index width addresses the memory; the count width must also hold the
  // number of entries itself.
  localparam int unsigned IdxW = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(FILTER_ENTRIES + 1);
  localparam int unsigned MemW = 2 * ID_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  // Filter memory: each word holds {mask, identifier}. One write port used by
  // add, one registered read port used by the frame walk. The two never run at
  // the same time, so no forwarding is needed.
  logic [MemW-1:0] filter_mem [FILTER_ENTRIES];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [MemW-1:0] mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic [MemW-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      filter_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= filter_mem[mem_raddr];
    end
  end

  // Control and payload registers.
  state_e                         state_q, state_d;
  logic [CntW-1:0]                entry_count_q, entry_count_d;
  logic [cmft_pkg::ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic [cmft_pkg::ElapsedW-1:0]  timeout_q, timeout_d;
  logic [ID_BITS-1:0]             fid_q, fid_d;
  logic [cmft_pkg::DataW-1:0]     fdata_q, fdata_d;
  logic [CntW-1:0]                rd_idx_q, rd_idx_d;
  logic                           rd_more_q, rd_more_d;
  logic                           cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]                cmp_idx_q, cmp_idx_d;
  logic                           pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]                pend_idx_q, pend_idx_d;
  logic [cmft_pkg::ResCntW-1:0]   res_cnt_q, res_cnt_d;
  logic                           out_valid_q, out_valid_d;
  cmft_pkg::kind_e                kind_q, kind_d;
  logic [cmft_pkg::OutIdxW-1:0]   idx_q, idx_d;
  logic [cmft_pkg::IdW-1:0]       frame_id_q, frame_id_d;
  logic [cmft_pkg::DataW-1:0]     payload_q, payload_d;
  logic                           alive_q, alive_d;
  logic                           last_q, last_d;

  logic               out_free;
  logic               in_accept;
  logic               out_load;
  logic [ID_BITS-1:0] ident_cut;
  logic [ID_BITS-1:0] mask_cut;
  logic [ID_BITS-1:0] stored_id;
  logic [ID_BITS-1:0] stored_mask;
  logic               hit;
  logic               produce;
  logic               stall;
  logic [CntW-1:0]    rd_idx_inc;

  assign ident_cut   = ident_i[ID_BITS-1:0];
  assign mask_cut    = mask_i[ID_BITS-1:0];
  assign stored_id   = mem_rdata_q[ID_BITS-1:0];
  assign stored_mask = mem_rdata_q[MemW-1:ID_BITS];
  assign rd_idx_inc  = rd_idx_q + CntW'(1);

  // The output register can take a new result when it is empty or its
  // current result is being taken in this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // Compare stage of the walk. A hit beyond the result limit still clears
  // the elapsed counter but gives no result.
  assign hit     = cmp_valid_q && (stored_id == (fid_q & stored_mask));
  assign produce = hit && (res_cnt_q < cmft_pkg::ResCntW'(cmft_pkg::MaxResults));
  // A new match must push the held one out; wait while the output is busy.
  assign stall   = produce && pend_valid_q && !out_free;

  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    elapsed_d     = elapsed_q;
    timeout_d     = cfg_we_i ? cfg_wdata_i : timeout_q;
    fid_d         = fid_q;
    fdata_d       = fdata_q;
    rd_idx_d      = rd_idx_q;
    rd_more_d     = rd_more_q;
    cmp_valid_d   = cmp_valid_q;
    cmp_idx_d     = cmp_idx_q;
    pend_valid_d  = pend_valid_q;
    pend_idx_d    = pend_idx_q;
    res_cnt_d     = res_cnt_q;
    kind_d        = kind_q;
    idx_d         = idx_q;
    frame_id_d    = frame_id_q;
    payload_d     = payload_q;
    last_d        = last_q;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = entry_count_q[IdxW-1:0];
    mem_wdata     = {mask_cut, ident_cut};
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (func_i)
            cmft_pkg::FUNC_ADD: begin
              out_load   = 1'b1;
              frame_id_d = '0;
              payload_d  = '0;
              last_d     = 1'b1;
              if (entry_count_q < CntW'(FILTER_ENTRIES)) begin
                mem_we        = 1'b1;
                kind_d        = cmft_pkg::KIND_ADDED;
                idx_d         = cmft_pkg::out_idx_t'(entry_count_q);
                entry_count_d = entry_count_q + CntW'(1);
              end else begin
                kind_d = cmft_pkg::KIND_FULL;
                idx_d  = '0;
              end
            end
            cmft_pkg::FUNC_FRAME: begin
              fid_d       = ident_cut;
              fdata_d     = frame_data_i;
              rd_idx_d    = '0;
              rd_more_d   = 1'b1;
              cmp_valid_d = 1'b0;
              res_cnt_d   = '0;
              // An empty table gives no result at all.
              if (entry_count_q != '0) begin
                state_d = ST_WALK;
              end
            end
            cmft_pkg::FUNC_TICK: begin
              if (elapsed_q != cmft_pkg::ElapsedMax) begin
                elapsed_d = elapsed_q + cmft_pkg::ElapsedW'(1);
              end
              out_load   = 1'b1;
              kind_d     = cmft_pkg::KIND_TICK;
              idx_d      = '0;
              frame_id_d = '0;
              payload_d  = '0;
              last_d     = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        if (hit) begin
          elapsed_d = '0;
        end
        if (!stall) begin
          if (produce) begin
            if (pend_valid_q) begin
              out_load   = 1'b1;
              kind_d     = cmft_pkg::KIND_MATCH;
              idx_d      = cmft_pkg::out_idx_t'(pend_idx_q);
              frame_id_d = cmft_pkg::id_t'(fid_q);
              payload_d  = fdata_q;
              last_d     = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = cmp_idx_q;
            res_cnt_d    = res_cnt_q + cmft_pkg::ResCntW'(1);
          end
          if (rd_more_q) begin
            mem_re      = 1'b1;
            cmp_valid_d = 1'b1;
            cmp_idx_d   = rd_idx_q[IdxW-1:0];
            rd_idx_d    = rd_idx_inc;
            rd_more_d   = (rd_idx_inc < entry_count_q);
          end else begin
            cmp_valid_d = 1'b0;
          end
        end
        if (!rd_more_q && !cmp_valid_q) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          kind_d       = cmft_pkg::KIND_MATCH;
          idx_d        = cmft_pkg::out_idx_t'(pend_idx_q);
          frame_id_d   = cmft_pkg::id_t'(fid_q);
          payload_d    = fdata_q;
          last_d       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Alive is taken after this item's update of the elapsed counter.
    alive_d     = out_load ? (elapsed_d < timeout_q) : alive_q;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      elapsed_q     <= cmft_pkg::ElapsedMax;
      timeout_q     <= cmft_pkg::TimeoutReset;
      fid_q         <= '0;
      fdata_q       <= '0;
      rd_idx_q      <= '0;
      rd_more_q     <= 1'b0;
      cmp_valid_q   <= 1'b0;
      cmp_idx_q     <= '0;
      pend_valid_q  <= 1'b0;
      pend_idx_q    <= '0;
      res_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      kind_q        <= cmft_pkg::KIND_ADDED;
      idx_q         <= '0;
      frame_id_q    <= '0;
      payload_q     <= '0;
      alive_q       <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      elapsed_q     <= elapsed_d;
      timeout_q     <= timeout_d;
      fid_q         <= fid_d;
      fdata_q       <= fdata_d;
      rd_idx_q      <= rd_idx_d;
      rd_more_q     <= rd_more_d;
      cmp_valid_q   <= cmp_valid_d;
      cmp_idx_q     <= cmp_idx_d;
      pend_valid_q  <= pend_valid_d;
      pend_idx_q    <= pend_idx_d;
      res_cnt_q     <= res_cnt_d;
      out_valid_q   <= out_valid_d;
      kind_q        <= kind_d;
      idx_q         <= idx_d;
      frame_id_q    <= frame_id_d;
      payload_q     <= payload_d;
      alive_q       <= alive_d;
      last_q        <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign match_index_o = idx_q;
  assign frame_id_o    = frame_id_q;
  assign payload_o     = payload_q;
  assign alive_o       = alive_q;
  assign last_o        = last_q;

  // The table never holds more entries than the memory has words.
  `CMFT_ASSERT(a_count_bound, entry_count_q <= CntW'(FILTER_ENTRIES), "entry count overflow")
  // A result is only loaded when the output register can take it.
  `CMFT_ASSERT_ALWAYS(a_no_overwrite, out_load |-> out_free, "result overwritten")
  // A held match never survives the end of a frame walk.
  `CMFT_ASSERT(a_pend_idle, (state_q == ST_IDLE) |-> !pend_valid_q, "match left behind")
  // The compare stage is empty whenever a new item may be accepted.
  `CMFT_ASSERT(a_cmp_idle, (state_q == ST_IDLE) |-> !cmp_valid_q, "compare stage busy")
  // The number of results of one frame stays within the limit.
  `CMFT_ASSERT(a_res_bound, res_cnt_q <= cmft_pkg::ResCntW'(cmft_pkg::MaxResults),
               "too many results")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the CAN acceptance filter table.
`timescale 1ns / 1ps

module tb_top;

  // The table is built at its full size, with full 29-bit extended identifiers.
  localparam int unsigned TableDepth   = 32;
  localparam int unsigned IdBits       = 29;
  // The one function code that the block must ignore.
  localparam logic [cmft_pkg::FuncW-1:0] FuncUnused = 2'd3;
  // The usual mask of software that does not set one.
  localparam cmft_pkg::id_t SoftwareMask = 29'h0000FFFF;
  localparam cmft_pkg::id_t IdKeep       = cmft_pkg::id_t'((64'd1 << IdBits) - 64'd1);
  // A frame walks at most 32 entries, so this margin covers a walk that gives
  // no result before the block is idle.
  localparam int unsigned WalkSettle   = 40;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned StallPercent = 28;
  localparam int unsigned RandomItems  = 136;
  localparam int unsigned MaxPrinted   = 40;
  localparam int unsigned RunLimitNs   = 1000000;

  typedef struct packed {
    cmft_pkg::kind_e            kind;
    cmft_pkg::out_idx_t         index;
    cmft_pkg::id_t              frame_id;
    logic [cmft_pkg::DataW-1:0] payload;
    logic                       alive;
    logic                       last;
  } filter_result_t;

  // Every input is known from time zero; reset is held low from the start.
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_we_i     = 1'b0;
  logic [cmft_pkg::ElapsedW-1:0] cfg_wdata_i  = '0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic [cmft_pkg::FuncW-1:0]    func_i       = '0;
  cmft_pkg::id_t                 ident_i      = '0;
  cmft_pkg::id_t                 mask_i       = '0;
  logic [cmft_pkg::DataW-1:0]    frame_data_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [cmft_pkg::KindW-1:0]    kind_o;
  cmft_pkg::out_idx_t            match_index_o;
  cmft_pkg::id_t                 frame_id_o;
  logic [cmft_pkg::DataW-1:0]    payload_o;
  logic                          alive_o;
  logic                          last_o;

  // The testbench's own copy of the filter table, the watchdog and its timeout.
  cmft_pkg::id_t                 filter_id_copy [TableDepth];
  cmft_pkg::id_t                 filter_mask_copy [TableDepth];
  int unsigned                   table_fill = 0;
  logic [cmft_pkg::ElapsedW-1:0] elapsed_ms = cmft_pkg::ElapsedMax;
  logic [cmft_pkg::ElapsedW-1:0] timeout_ms = cmft_pkg::TimeoutReset;

  // Results that the block still owes, oldest first.
  filter_result_t filter_results_due [$];

  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned adds_sent       = 0;
  int unsigned frames_sent     = 0;
  int unsigned ticks_sent      = 0;
  int unsigned ignored_sent    = 0;
  // While set, neither side of the block idles.
  bit          no_stall        = 1'b0;

  can_id_mask_filter_table #(
    .FILTER_ENTRIES(TableDepth),
    .ID_BITS       (IdBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .ident_i      (ident_i),
    .mask_i       (mask_i),
    .frame_data_i (frame_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .match_index_o(match_index_o),
    .frame_id_o   (frame_id_o),
    .payload_o    (payload_o),
    .alive_o      (alive_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiving side stalls at random, except during the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(0, 99) >= StallPercent);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MaxPrinted) begin
      $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // The watchdog status is taken after the item has updated the counter.
  function automatic filter_result_t make_result(cmft_pkg::kind_e kind,
                                                 cmft_pkg::out_idx_t index,
                                                 cmft_pkg::id_t fid,
                                                 logic [cmft_pkg::DataW-1:0] payload);
    filter_result_t res;
    res.kind     = kind;
    res.index    = index;
    res.frame_id = fid;
    res.payload  = payload;
    res.alive    = (elapsed_ms < timeout_ms);
    res.last     = 1'b0;
    return res;
  endfunction

  // Applies one accepted item to the copy of the table and queues the results
  // that it must cause.
  task automatic filter_table_step(logic [cmft_pkg::FuncW-1:0] func, cmft_pkg::id_t ident,
                                   cmft_pkg::id_t mask, logic [cmft_pkg::DataW-1:0] data);
    filter_result_t batch [$];
    cmft_pkg::id_t  id_cut;
    cmft_pkg::id_t  mask_cut;
    id_cut   = ident & IdKeep;
    mask_cut = mask & IdKeep;
    case (func)
      cmft_pkg::FUNC_ADD: begin
        if (table_fill < TableDepth) begin
          filter_id_copy[table_fill]   = id_cut;
          filter_mask_copy[table_fill] = mask_cut;
          batch.push_back(make_result(cmft_pkg::KIND_ADDED,
                                      cmft_pkg::out_idx_t'(table_fill), '0, '0));
          table_fill++;
        end else begin
          batch.push_back(make_result(cmft_pkg::KIND_FULL, '0, '0, '0));
        end
        adds_sent++;
      end
      cmft_pkg::FUNC_FRAME: begin
        // Every match clears the watchdog, even one beyond the result limit.
        for (int i = 0; i < table_fill; i++) begin
          if (filter_id_copy[i] == (id_cut & filter_mask_copy[i])) begin
            elapsed_ms = '0;
            if (batch.size() < cmft_pkg::MaxResults) begin
              batch.push_back(make_result(cmft_pkg::KIND_MATCH, cmft_pkg::out_idx_t'(i),
                                          id_cut, data));
            end
          end
        end
        frames_sent++;
      end
      cmft_pkg::FUNC_TICK: begin
        if (elapsed_ms != cmft_pkg::ElapsedMax) begin
          elapsed_ms++;
        end
        batch.push_back(make_result(cmft_pkg::KIND_TICK, '0, '0, '0));
        ticks_sent++;
      end
      default: begin
        ignored_sent++;
      end
    endcase
    if (batch.size() != 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[k]) begin
      filter_results_due.push_back(batch[k]);
    end
  endtask

  // Offers one item, after a random idle spell, and holds it until it is taken.
  // Valid is only lowered during an idle spell, so it never drops and rises in
  // the same step when items follow back to back.
  task automatic send_item(logic [cmft_pkg::FuncW-1:0] func, cmft_pkg::id_t ident,
                           cmft_pkg::id_t mask, logic [cmft_pkg::DataW-1:0] data);
    while (!no_stall && $urandom_range(0, 99) < StallPercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    ident_i      <= ident;
    mask_i       <= mask;
    frame_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    filter_table_step(func, ident, mask, data);
  endtask

  // Waits for every owed result, then for a walk that may give none.
  task automatic wait_until_idle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (filter_results_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (WalkSettle) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [cmft_pkg::ElapsedW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    timeout_ms  = value;
  endtask

  task automatic send_random_add();
    cmft_pkg::id_t id_v;
    cmft_pkg::id_t mask_v;
    case ($urandom_range(0, 7))
      0, 1: begin
        // An entry that takes every frame.
        id_v   = '0;
        mask_v = '0;
      end
      2: begin
        mask_v = SoftwareMask;
        id_v   = cmft_pkg::id_t'($urandom) & mask_v;
      end
      3: begin
        // Identifier bits outside the mask: such an entry can never match.
        id_v   = cmft_pkg::id_t'($urandom);
        mask_v = cmft_pkg::id_t'($urandom);
      end
      default: begin
        mask_v = cmft_pkg::id_t'($urandom);
        id_v   = cmft_pkg::id_t'($urandom) & mask_v;
      end
    endcase
    send_item(cmft_pkg::FUNC_ADD, id_v, mask_v, {$urandom, $urandom});
  endtask

  // Mostly frames aimed at a stored entry, with random bits where its mask is
  // clear, so that the walk finds matches; the rest are random identifiers.
  task automatic send_random_frame();
    cmft_pkg::id_t ident_v;
    int unsigned   pick;
    if (table_fill != 0 && $urandom_range(0, 9) < 7) begin
      pick    = $urandom_range(0, table_fill - 1);
      ident_v = filter_id_copy[pick] | (cmft_pkg::id_t'($urandom) & ~filter_mask_copy[pick]);
    end else begin
      ident_v = cmft_pkg::id_t'($urandom);
    end
    send_item(cmft_pkg::FUNC_FRAME, ident_v, cmft_pkg::id_t'($urandom), {$urandom, $urandom});
  endtask

  // After reset the table is empty and the counter is saturated, so nothing
  // is alive and no frame can match.
  task automatic test_reset_state();
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
    send_item(cmft_pkg::FUNC_FRAME, IdKeep, IdKeep, '1);
    send_item(FuncUnused, IdKeep, IdKeep, '1);
    // With the largest timeout a tick must leave the counter saturated rather
    // than wrap it to zero, which would report alive.
    wait_until_idle();
    write_timeout(16'hFFFF);
    send_item(cmft_pkg::FUNC_TICK, IdKeep, '0, '1);
  endtask

  // A few hand-picked entries: an exact match on all ones, a software-style
  // 16-bit mask, a catch-all and an alternating pattern.
  task automatic test_add_and_match();
    send_item(cmft_pkg::FUNC_ADD, IdKeep, IdKeep, '0);
    send_item(cmft_pkg::FUNC_ADD, cmft_pkg::id_t'(29'h0000_0123), SoftwareMask, '1);
    // Matches neither entry, so no result and the counter stays saturated.
    send_item(cmft_pkg::FUNC_FRAME, '0, '0, 64'h0123_4567_89AB_CDEF);
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
    send_item(cmft_pkg::FUNC_FRAME, IdKeep, '0, '1);
    send_item(cmft_pkg::FUNC_FRAME, cmft_pkg::id_t'(29'h1ABC_0123), IdKeep, '0);
    send_item(cmft_pkg::FUNC_ADD, '0, '0, '0);
    send_item(cmft_pkg::FUNC_ADD, cmft_pkg::id_t'(29'h1555_5555),
              cmft_pkg::id_t'(29'h1555_5555), '0);
    // Three entries match one frame; only the third result is marked last.
    send_item(cmft_pkg::FUNC_FRAME, IdKeep, cmft_pkg::id_t'(29'h0AAA_AAAA),
              64'hAAAA_AAAA_5555_5555);
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
  endtask

  // A zero timeout is never alive; a timeout of one is alive only right after
  // a match. The reset value is restored afterwards.
  task automatic test_timeout_register();
    wait_until_idle();
    write_timeout('0);
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
    send_item(cmft_pkg::FUNC_FRAME, IdKeep, '0, 64'h8000_0000_0000_0001);
    wait_until_idle();
    write_timeout(16'd1);
    send_item(cmft_pkg::FUNC_FRAME, IdKeep, '0, 64'h0000_0000_FFFF_FFFF);
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
    wait_until_idle();
    write_timeout(cmft_pkg::TimeoutReset);
  endtask

  // Four phases, each under its own timeout. Short timeouts make alive toggle
  // between ticks and matches; the third phase runs with no idling at all.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned roll;
    for (int phase = 0; phase < 4; phase++) begin
      wait_until_idle();
      case (phase)
        0:       write_timeout(16'd3);
        1:       write_timeout(16'd1);
        2:       write_timeout(16'($urandom_range(4, 40)));
        default: write_timeout(16'($urandom_range(1, 65535)));
      endcase
      no_stall <= (phase == 2);
      sent = 0;
      while (sent < RandomItems / 4) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          send_random_add();
          sent++;
        end else if (roll < 68) begin
          send_random_frame();
          sent++;
        end else if (roll < 95) begin
          send_item(cmft_pkg::FUNC_TICK, cmft_pkg::id_t'($urandom), cmft_pkg::id_t'($urandom),
                    {$urandom, $urandom});
          sent++;
        end else begin
          // Noise on the unused function code; it does not count as traffic.
          send_item(FuncUnused, cmft_pkg::id_t'($urandom), cmft_pkg::id_t'($urandom),
                    {$urandom, $urandom});
        end
      end
    end
    no_stall <= 1'b0;
  endtask

  // Fills whatever room is left, then adds to a full table. A frame with a
  // zero identifier then hits every entry whose identifier is zero.
  task automatic test_table_full();
    while (table_fill < TableDepth) begin
      send_random_add();
    end
    send_item(cmft_pkg::FUNC_ADD, IdKeep, IdKeep, '1);
    send_item(cmft_pkg::FUNC_ADD, '0, '0, '0);
    send_item(cmft_pkg::FUNC_FRAME, '0, IdKeep, {$urandom, $urandom});
    send_random_frame();
    send_item(cmft_pkg::FUNC_TICK, '0, '0, '0);
  endtask

  // Each accepted result is compared field by field with the oldest one owed.
  always @(posedge clk_i) begin : check_results
    filter_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filter_results_due.size() == 0) begin
        report_mismatch("result with none owed, kind", 64'(kind_o), '0);
      end else begin
        want = filter_results_due.pop_front();
        results_checked++;
        if (kind_o !== want.kind) begin
          report_mismatch("kind", 64'(kind_o), 64'(want.kind));
        end
        if (match_index_o !== want.index) begin
          report_mismatch("match_index", 64'(match_index_o), 64'(want.index));
        end
        if (frame_id_o !== want.frame_id) begin
          report_mismatch("frame_id", 64'(frame_id_o), 64'(want.frame_id));
        end
        if (payload_o !== want.payload) begin
          report_mismatch("payload", payload_o, want.payload);
        end
        if (alive_o !== want.alive) begin
          report_mismatch("alive", 64'(alive_o), 64'(want.alive));
        end
        if (last_o !== want.last) begin
          report_mismatch("last", 64'(last_o), 64'(want.last));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_add_and_match();
    test_timeout_register();
    test_random_traffic();
    test_table_full();
    wait_until_idle();
    if (filter_results_due.size() != 0) begin
      report_mismatch("results never delivered", 64'(filter_results_due.size()), '0);
    end
    $display("Covered %0d adds, %0d frames, %0d ticks and %0d ignored items; table holds %0d.",
             adds_sent, frames_sent, ticks_sent, ignored_sent, table_fill);
    $display("Compared %0d results under several timeouts, zero and the maximum among them.",
             results_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(RunLimitNs);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/cmft_pkg.sv
src/can_id_mask_filter_table.sv
tb/tb_top.sv
